>>> rtl/lcd_mode_line_timer_core_macros.svh
// Assertion macros used by the checker file.
`ifndef LCD_MODE_LINE_TIMER_CORE_MACROS_SVH
`define LCD_MODE_LINE_TIMER_CORE_MACROS_SVH

// Property checked on every rising clock edge, off while reset is active.
`define LCDMLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The same, with an enable term that gates the property.
`define LCDMLT_ASSERT_IF(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) else $error(msg);

`endif

>>> rtl/lcdmlt_pkg.sv
package lcdmlt_pkg;

  localparam int unsigned CYCLES_PER_LINE = 456;
  localparam int unsigned OAM_CYCLES      = 80;
  localparam int unsigned TRANSFER_CYCLES = 172;
  localparam int unsigned VISIBLE_LINES   = 144;
  localparam int unsigned LAST_LINE       = 153;

  localparam int unsigned CNT_W  = 10;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned IDX_W  = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_LCD_ENABLE     = 3'd0,
    CFG_HBLANK_IRQ_EN  = 3'd1,
    CFG_VBLANK_IRQ_EN  = 3'd2,
    CFG_OAM_IRQ_EN     = 3'd3,
    CFG_COMPARE_IRQ_EN = 3'd4,
    CFG_COMPARE_LINE   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    lcd_mode_e         lcd_mode;
    logic              coincidence;
    logic              status_irq;
    logic              vblank_irq;
    logic              draw_line;
    logic [LINE_W-1:0] drawn_line;
  } result_t;

endpackage

>>> rtl/lcd_mode_line_timer_core.sv
// LCD mode and line timer.
// Input channel (in_valid_i / in_stall_o): one transfer per CPU step, giving
// the cycles spent since the previous step. Output channel (out_valid_o /
// out_stall_i): one transfer per input transfer, carrying the line after the
// step, the mode judged at the start of the step, the coincidence flag, the
// status and vblank interrupt requests and the line-draw event.
// The line counter, countdown and mode update in the accepting cycle and the
// result is registered. Throughput is one item per cycle while in_stall_o is
// low; the countdown subtract and threshold compares form the only path.
// A result register plus a skid register decouple the sides, so input is
// taken while a result waits; in_stall_o rises only when both are full.
// The user writes the configuration port (cfg_we_i, cfg_idx_i, cfg_data_i)
// only while idle (unenforced). Indexes past the compare line are ignored.
// Reset: display on, all interrupt enables off, compare line 0, countdown at
// a full line, line 0, mode 0, both output registers empty.
// With the display off each step reports line 0, mode 1 and no events.
module lcd_mode_line_timer_core #(
  parameter int unsigned CyclesPerLine  = lcdmlt_pkg::CYCLES_PER_LINE,
  parameter int unsigned OamCycles      = lcdmlt_pkg::OAM_CYCLES,
  parameter int unsigned TransferCycles = lcdmlt_pkg::TRANSFER_CYCLES,
  parameter int unsigned VisibleLines   = lcdmlt_pkg::VISIBLE_LINES,
  parameter int unsigned LastLine       = lcdmlt_pkg::LAST_LINE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcdmlt_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [lcdmlt_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     elapsed_cycles_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     current_line_o,
  output logic [1:0]                     lcd_mode_o,
  output logic                           coincidence_o,
  output logic                           status_irq_o,
  output logic                           vblank_irq_o,
  output logic                           draw_line_o,
  output logic [7:0]                     drawn_line_o
);

  localparam int unsigned CntW  = lcdmlt_pkg::CNT_W;
  localparam int unsigned LineW = lcdmlt_pkg::LINE_W;
  localparam int unsigned DiffW = CntW + 2;

  localparam logic [CntW-1:0]         CntReload = CntW'(CyclesPerLine);
  localparam logic signed [DiffW-1:0] OamThr    =
      DiffW'(int'(CyclesPerLine) - int'(OamCycles));
  localparam logic signed [DiffW-1:0] XferThr   =
      DiffW'(int'(CyclesPerLine) - int'(OamCycles) - int'(TransferCycles));
  localparam logic [LineW-1:0]        VisLine   = LineW'(VisibleLines);
  localparam logic [LineW-1:0]        EndLine   = LineW'(LastLine);

  // configuration
  logic              lcd_en_q, hbl_ie_q, vbl_ie_q, oam_ie_q, cmp_ie_q;
  logic [LineW-1:0]  cmp_line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_en_q   <= 1'b1;
      hbl_ie_q   <= 1'b0;
      vbl_ie_q   <= 1'b0;
      oam_ie_q   <= 1'b0;
      cmp_ie_q   <= 1'b0;
      cmp_line_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdmlt_pkg::CFG_LCD_ENABLE:     lcd_en_q   <= cfg_data_i[0];
        lcdmlt_pkg::CFG_HBLANK_IRQ_EN:  hbl_ie_q   <= cfg_data_i[0];
        lcdmlt_pkg::CFG_VBLANK_IRQ_EN:  vbl_ie_q   <= cfg_data_i[0];
        lcdmlt_pkg::CFG_OAM_IRQ_EN:     oam_ie_q   <= cfg_data_i[0];
        lcdmlt_pkg::CFG_COMPARE_IRQ_EN: cmp_ie_q   <= cfg_data_i[0];
        lcdmlt_pkg::CFG_COMPARE_LINE:   cmp_line_q <= cfg_data_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  // timer state
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [LineW-1:0]      line_q, line_d;
  lcdmlt_pkg::lcd_mode_e mode_q, mode_d;

  logic                    in_fire;
  logic signed [DiffW-1:0] cnt_s, diff;
  logic                    expired, mode_irq;
  lcdmlt_pkg::lcd_mode_e   mode_new;
  lcdmlt_pkg::result_t     res;

  assign in_fire = in_valid_i && !in_stall_o;
  assign cnt_s   = $signed({2'b00, cnt_q});
  assign diff    = cnt_s - $signed({{(DiffW-8){1'b0}}, elapsed_cycles_i});
  assign expired = diff[DiffW-1] || (diff == '0);

  always_comb begin
    if (line_q >= VisLine) begin
      mode_new = lcdmlt_pkg::MODE_VBLANK;
      mode_irq = vbl_ie_q;
    end else if (cnt_s >= OamThr) begin
      mode_new = lcdmlt_pkg::MODE_OAM;
      mode_irq = oam_ie_q;
    end else if (cnt_s >= XferThr) begin
      mode_new = lcdmlt_pkg::MODE_XFER;
      mode_irq = 1'b0;
    end else begin
      mode_new = lcdmlt_pkg::MODE_HBLANK;
      mode_irq = hbl_ie_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    line_d = line_q;
    mode_d = mode_q;
    res    = '0;
    if (!lcd_en_q) begin
      cnt_d        = CntReload;
      line_d       = '0;
      mode_d       = lcdmlt_pkg::MODE_VBLANK;
      res.lcd_mode = lcdmlt_pkg::MODE_VBLANK;
    end else begin
      mode_d          = mode_new;
      res.lcd_mode    = mode_new;
      res.coincidence = (line_q == cmp_line_q);
      res.status_irq  = (mode_irq && (mode_new != mode_q)) ||
                        (res.coincidence && cmp_ie_q);
      if (expired) begin
        cnt_d          = CntReload;
        res.draw_line  = (line_q < VisLine);
        res.drawn_line = (line_q < VisLine) ? line_q : '0;
        res.vblank_irq = (line_q == VisLine);
        line_d         = (line_q >= EndLine) ? '0 : line_q + 1'b1;
      end else begin
        cnt_d = diff[CntW-1:0];
      end
      res.current_line = line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CntReload;
      line_q <= '0;
      mode_q <= lcdmlt_pkg::MODE_HBLANK;
    end else if (in_fire) begin
      cnt_q  <= cnt_d;
      line_q <= line_d;
      mode_q <= mode_d;
    end
  end

  // result register and skid stage
  logic                out_vld_q, skid_vld_q;
  lcdmlt_pkg::result_t out_q, skid_q;

  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q  <= skid_vld_q || in_fire;
      skid_vld_q <= 1'b0;
    end else if (in_fire) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign current_line_o = out_q.current_line;
  assign lcd_mode_o     = out_q.lcd_mode;
  assign coincidence_o  = out_q.coincidence;
  assign status_irq_o   = out_q.status_irq;
  assign vblank_irq_o   = out_q.vblank_irq;
  assign draw_line_o    = out_q.draw_line;
  assign drawn_line_o   = out_q.drawn_line;

endmodule

>>> rtl/lcdmlt_checker.sv
`include "lcd_mode_line_timer_core_macros.svh"

module lcdmlt_checker #(
  parameter int unsigned VisibleLines = lcdmlt_pkg::VISIBLE_LINES
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [lcdmlt_pkg::IDX_W-1:0] cfg_idx_i,
  input logic [lcdmlt_pkg::CFG_W-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [7:0]                   elapsed_cycles_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [7:0]                   current_line_o,
  input logic [1:0]                   lcd_mode_o,
  input logic                         coincidence_o,
  input logic                         status_irq_o,
  input logic                         vblank_irq_o,
  input logic                         draw_line_o,
  input logic [7:0]                   drawn_line_o
);

  localparam logic [7:0] VisLine = 8'(VisibleLines);

  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_idx_i) ^ (^cfg_data_i) ^ in_valid_i ^
                      in_stall_o ^ (^elapsed_cycles_i) ^ (^current_line_o) ^
                      coincidence_o ^ status_irq_o;

  // a stalled result holds
  `LCDMLT_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(current_line_o) &&
    $stable(lcd_mode_o) && $stable(status_irq_o) && $stable(drawn_line_o),
    "stalled result changed")

  // end of the first blank line: mode is vblank and nothing is drawn
  `LCDMLT_ASSERT_IF(a_vblank, clk_i, rst_ni, out_valid_o && vblank_irq_o,
    lcd_mode_o == lcdmlt_pkg::MODE_VBLANK && !draw_line_o,
    "vblank event outside vblank mode or with draw")

  // a drawn line is visible and was not in vblank mode
  `LCDMLT_ASSERT_IF(a_draw, clk_i, rst_ni, out_valid_o && draw_line_o,
    drawn_line_o < VisLine && lcd_mode_o != lcdmlt_pkg::MODE_VBLANK,
    "draw event for a blank line")

  `LCDMLT_ASSERT_IF(a_nodraw, clk_i, rst_ni, out_valid_o && !draw_line_o,
    drawn_line_o == 8'd0, "drawn line set without draw event")

endmodule

bind lcd_mode_line_timer_core lcdmlt_checker #(
  .VisibleLines(VisibleLines)
) u_lcdmlt_checker (.*);

>>> verif/lcd_mode_line_timer_core_tb.sv
`timescale 1ns / 1ps

module lcd_mode_line_timer_core_tb;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic [7:0] BOUNDARY_WALK [10] = '{
    8'd0, 8'd80, 8'd1, 8'd171, 8'd1, 8'd203, 8'd255, 8'd255, 8'd170, 8'd85
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lcdmlt_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [lcdmlt_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] elapsed_cycles_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] current_line_o;
  logic [1:0] lcd_mode_o;
  logic coincidence_o;
  logic status_irq_o;
  logic vblank_irq_o;
  logic draw_line_o;
  logic [7:0] drawn_line_o;

  // timer state mirror
  int cyc_left = lcdmlt_pkg::CYCLES_PER_LINE;
  logic [7:0] line_no = '0;
  lcdmlt_pkg::lcd_mode_e mode_prev = lcdmlt_pkg::MODE_HBLANK;
  bit disp_on = 1'b1;
  bit hblank_ie = 1'b0;
  bit vblank_ie = 1'b0;
  bit oam_ie = 1'b0;
  bit lyc_ie = 1'b0;
  logic [7:0] lyc = '0;

  lcdmlt_pkg::result_t line_results_q[$];
  int unsigned mismatches = 0;

  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit run_stall = 1'b0;

  lcd_mode_line_timer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .elapsed_cycles_i (elapsed_cycles_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .current_line_o   (current_line_o),
    .lcd_mode_o       (lcd_mode_o),
    .coincidence_o    (coincidence_o),
    .status_irq_o     (status_irq_o),
    .vblank_irq_o     (vblank_irq_o),
    .draw_line_o      (draw_line_o),
    .drawn_line_o     (drawn_line_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_spent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'($urandom_range(0, 15));
    if (r < 40) return 8'($urandom);
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic advance_timer(input logic [7:0] spent);
    lcdmlt_pkg::result_t r;
    lcdmlt_pkg::lcd_mode_e m;
    bit irq;
    r = '0;
    irq = 1'b0;
    if (!disp_on) begin
      cyc_left = lcdmlt_pkg::CYCLES_PER_LINE;
      line_no = '0;
      mode_prev = lcdmlt_pkg::MODE_VBLANK;
    end else begin
      if (line_no >= lcdmlt_pkg::VISIBLE_LINES) begin
        m = lcdmlt_pkg::MODE_VBLANK;
        irq = vblank_ie;
      end else if (cyc_left >= int'(lcdmlt_pkg::CYCLES_PER_LINE - lcdmlt_pkg::OAM_CYCLES)) begin
        m = lcdmlt_pkg::MODE_OAM;
        irq = oam_ie;
      end else if (cyc_left >= int'(lcdmlt_pkg::CYCLES_PER_LINE - lcdmlt_pkg::OAM_CYCLES -
                                    lcdmlt_pkg::TRANSFER_CYCLES)) begin
        m = lcdmlt_pkg::MODE_XFER;
      end else begin
        m = lcdmlt_pkg::MODE_HBLANK;
        irq = hblank_ie;
      end
      if (m == mode_prev) irq = 1'b0;
      mode_prev = m;
      if (line_no == lyc) begin
        r.coincidence = 1'b1;
        if (lyc_ie) irq = 1'b1;
      end
      cyc_left -= int'(spent);
      if (cyc_left <= 0) begin
        cyc_left = lcdmlt_pkg::CYCLES_PER_LINE;
        if (line_no < lcdmlt_pkg::VISIBLE_LINES) begin
          r.draw_line = 1'b1;
          r.drawn_line = line_no;
        end
        if (line_no == lcdmlt_pkg::VISIBLE_LINES) r.vblank_irq = 1'b1;
        line_no = (line_no >= lcdmlt_pkg::LAST_LINE) ? 8'd0 : line_no + 8'd1;
      end
    end
    r.current_line = line_no;
    r.lcd_mode = mode_prev;
    r.status_irq = irq;
    line_results_q.push_back(r);
  endtask

  // leaves valid high; caller sends again or drains in the same step
  task automatic send_step(input logic [7:0] spent);
    int unsigned gap;
    bit took;
    gap = tx_eager ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_cycles_i <= spent;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    advance_timer(spent);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // leaves the write enable high; caller lowers it after the last write
  task automatic cfg_write(input logic [lcdmlt_pkg::IDX_W-1:0] idx,
                           input logic [lcdmlt_pkg::CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      lcdmlt_pkg::CFG_LCD_ENABLE:     disp_on = data[0];
      lcdmlt_pkg::CFG_HBLANK_IRQ_EN:  hblank_ie = data[0];
      lcdmlt_pkg::CFG_VBLANK_IRQ_EN:  vblank_ie = data[0];
      lcdmlt_pkg::CFG_OAM_IRQ_EN:     oam_ie = data[0];
      lcdmlt_pkg::CFG_COMPARE_IRQ_EN: lyc_ie = data[0];
      lcdmlt_pkg::CFG_COMPARE_LINE:   lyc = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input bit on, input bit hb, input bit vb, input bit oam,
                             input bit cmp, input logic [7:0] cmp_line);
    drain_results();
    cfg_write(lcdmlt_pkg::CFG_LCD_ENABLE, {7'($urandom), on});
    cfg_write(lcdmlt_pkg::CFG_HBLANK_IRQ_EN, {7'($urandom), hb});
    cfg_write(lcdmlt_pkg::CFG_VBLANK_IRQ_EN, {7'($urandom), vb});
    cfg_write(lcdmlt_pkg::CFG_OAM_IRQ_EN, {7'($urandom), oam});
    cfg_write(lcdmlt_pkg::CFG_COMPARE_IRQ_EN, {7'($urandom), cmp});
    cfg_write(lcdmlt_pkg::CFG_COMPARE_LINE, cmp_line);
    cfg_we_i <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    lcdmlt_pkg::result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (line_results_q.size() == 0) begin
        $display("%0t: result transfer with none expected: expected none, actual line %0d",
                 $time, current_line_o);
        mismatches++;
      end else begin
        want = line_results_q.pop_front();
        compare_field("current_line", want.current_line, current_line_o);
        compare_field("lcd_mode", 8'(want.lcd_mode), 8'(lcd_mode_o));
        compare_field("coincidence", 8'(want.coincidence), 8'(coincidence_o));
        compare_field("status_irq", 8'(want.status_irq), 8'(status_irq_o));
        compare_field("vblank_irq", 8'(want.vblank_irq), 8'(vblank_irq_o));
        compare_field("draw_line", 8'(want.draw_line), 8'(draw_line_o));
        compare_field("drawn_line", want.drawn_line, drawn_line_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_eager) begin
      out_stall_i <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(0, 2) == 0);
        run_left = run_stall ? idle_len() + 1 : $urandom_range(1, 12);
      end
      run_left--;
      out_stall_i <= run_stall;
    end
  end

  // exact mode thresholds from a fresh line, no idling
  task automatic test_mode_boundaries();
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    foreach (BOUNDARY_WALK[i]) send_step(BOUNDARY_WALK[i]);
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  task automatic test_status_irqs();
    load_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
    send_step(8'd0);
    load_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0);
    foreach (BOUNDARY_WALK[i]) send_step(BOUNDARY_WALK[i]);
  endtask

  task automatic test_display_off();
    load_config(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0);
    repeat (30) send_step(random_spent());
    load_config(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'd1);
    repeat (10) send_step(random_spent());
  endtask

  task automatic test_unused_registers();
    drain_results();
    for (int i = int'(lcdmlt_pkg::CFG_COMPARE_LINE) + 1; i < 2 ** lcdmlt_pkg::IDX_W; i++)
      cfg_write(lcdmlt_pkg::IDX_W'(i), lcdmlt_pkg::CFG_W'($urandom));
    cfg_we_i <= 1'b0;
    repeat (10) send_step(random_spent());
  endtask

  task automatic test_output_backpressure();
    drain_results();
    hold_req = 1'b1;
    tx_eager = 1'b1;
    repeat (40) send_step(random_spent());
    tx_eager = 1'b0;
  endtask

  task automatic test_random_frames();
    logic [7:0] cmp_line;
    bit [3:0] ie;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: cmp_line = 8'd0;
        1: cmp_line = 8'd255;
        2: cmp_line = 8'(lcdmlt_pkg::LAST_LINE);
        3: cmp_line = 8'(lcdmlt_pkg::VISIBLE_LINES);
        4: cmp_line = 8'($urandom_range(0, lcdmlt_pkg::LAST_LINE));
        default: cmp_line = 8'($urandom);
      endcase
      ie = (phase == 0) ? 4'hF : (phase == 1) ? 4'h0 : 4'($urandom);
      load_config(1'b1, ie[0], ie[1], ie[2], ie[3], cmp_line);
      repeat (200) send_step(random_spent());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mode_boundaries();
    test_status_irqs();
    test_display_off();
    test_unused_registers();
    test_output_backpressure();
    test_random_frames();
    drain_results();
    if (mismatches == 0) begin
      $display("** lcd_mode_line_timer_core: PASSED **");
    end else begin
      $display("** lcd_mode_line_timer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** lcd_mode_line_timer_core: FAILED **");
    $finish;
  end

endmodule
